@@ rtl/rtp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rtp_pkg;

  // Field widths.
  localparam int CHAR_W   = 8;
  localparam int TONE_W   = 4;
  localparam int OCT_W    = 4;
  localparam int FREQ_W   = 12;
  localparam int DUR_W    = 8;
  localparam int MS_W     = 16;
  localparam int STATUS_W = 2;
  localparam int OUT_DATA_W = 40;  // 36 bits of fields rounded up to whole bytes

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEFAULT_DURATION = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_OCTAVE   = 2'd1;
  localparam logic [1:0] CFG_WHOLE_NOTE_MS    = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_LETTER = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_DUR  = 2'd2;

  // Characters with a meaning to the parser.
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [TONE_W-1:0] TONE_REST = 4'd12;

  typedef enum logic [1:0] {
    PH_PRE    = 2'd0,  // before the letter, duration digits go here
    PH_LETTER = 2'd1,  // right after the letter
    PH_MOD    = 2'd2,  // after '#' or '.'
    PH_OCT    = 2'd3   // inside the octave digits
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_LOAD = 2'd2
  } seq_state_t;

  // One closed note, handed from the parser to the sequencer.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TONE_W-1:0]   tone;
    logic [OCT_W-1:0]    octave;
    logic [FREQ_W-1:0]   freq;
    logic [DUR_W-1:0]    dur;
  } note_t;

  // Base tone frequency divided by five, for C through B.
  function automatic logic [7:0] base_div5(input logic [TONE_W-1:0] tone);
    case (tone)
      4'd0:    base_div5 = 8'd104;
      4'd1:    base_div5 = 8'd110;
      4'd2:    base_div5 = 8'd117;
      4'd3:    base_div5 = 8'd124;
      4'd4:    base_div5 = 8'd132;
      4'd5:    base_div5 = 8'd139;
      4'd6:    base_div5 = 8'd148;
      4'd7:    base_div5 = 8'd156;
      4'd8:    base_div5 = 8'd166;
      4'd9:    base_div5 = 8'd176;
      4'd10:   base_div5 = 8'd186;
      4'd11:   base_div5 = 8'd197;
      default: base_div5 = 8'd0;
    endcase
  endfunction

  // Letter to semitone; the top bit flags a valid note letter.
  function automatic logic [TONE_W:0] letter_tone(input logic [CHAR_W-1:0] c);
    case (c)
      8'h63:   letter_tone = {1'b1, 4'd0};   // c
      8'h64:   letter_tone = {1'b1, 4'd2};   // d
      8'h65:   letter_tone = {1'b1, 4'd4};   // e
      8'h66:   letter_tone = {1'b1, 4'd5};   // f
      8'h67:   letter_tone = {1'b1, 4'd7};   // g
      8'h61:   letter_tone = {1'b1, 4'd9};   // a
      8'h62:   letter_tone = {1'b1, 4'd11};  // b
      8'h70:   letter_tone = {1'b1, TONE_REST};  // p
      default: letter_tone = {1'b0, 4'd0};
    endcase
  endfunction

endpackage

`default_nettype wire

@@ rtl/rtp_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient holds after done.
module rtp_divider (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [rtp_pkg::MS_W-1:0]  dividend,
  input  wire logic [rtp_pkg::DUR_W-1:0] divisor,
  output logic                          done,
  output logic [rtp_pkg::MS_W-1:0]       quotient
);
  import rtp_pkg::*;

  logic              busy;
  logic [3:0]        count;
  logic [DUR_W-1:0]  rem;
  logic [DUR_W-1:0]  dvs;
  logic [MS_W-1:0]   quo;
  logic [DUR_W:0]    trial;
  logic [DUR_W:0]    diff;
  logic              fits;

  assign trial = {rem, quo[MS_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 4'd1;
        if (count == 4'(MS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
      quo <= {quo[MS_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

@@ rtl/rtp_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Character parser: holds the note being built and reports a closed note.
module rtp_parser (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      accept,
  input  wire logic [rtp_pkg::CHAR_W-1:0] character,
  input  wire logic                      last_char,
  input  wire logic [rtp_pkg::DUR_W-1:0]  default_duration,
  input  wire logic [rtp_pkg::OCT_W-1:0]  default_octave,
  output logic                           emit,
  output rtp_pkg::note_t                 note
);
  import rtp_pkg::*;

  phase_t            phase, phase_next;
  logic [DUR_W-1:0]  dur_acc, dur_acc_next;
  logic              dur_seen, dur_seen_next;
  logic [TONE_W-1:0] tone, tone_next;
  logic [OCT_W-1:0]  oct_acc, oct_acc_next;
  logic              oct_seen, oct_seen_next;
  logic              pending, pending_next;

  logic              is_digit;
  logic              close;
  logic [3:0]        digit;
  logic [11:0]       dur_val;
  logic [7:0]        oct_val;
  logic [TONE_W:0]   letter;
  logic [OCT_W-1:0]  oct_pick;
  logic [DUR_W-1:0]  dur_pick;

  assign is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
  assign digit    = character[3:0];
  assign dur_val  = 12'(dur_acc) * 12'd10 + 12'(digit);
  assign oct_val  = 8'(oct_acc) * 8'd10 + 8'(digit);
  assign letter   = letter_tone(character);
  assign close    = (character == CH_COMMA) || last_char;

  always_comb begin
    phase_next    = phase;
    dur_acc_next  = dur_acc;
    dur_seen_next = dur_seen;
    tone_next     = tone;
    oct_acc_next  = oct_acc;
    oct_seen_next = oct_seen;
    pending_next  = pending;
    if (character != CH_COMMA && character != CH_SPACE) begin
      pending_next = 1'b1;
      if (is_digit) begin
        if (phase == PH_PRE) begin
          dur_acc_next  = (dur_val > 12'd255) ? 8'hFF : dur_val[7:0];
          dur_seen_next = 1'b1;
        end else begin
          oct_acc_next  = (oct_val > 8'd15) ? 4'hF : oct_val[3:0];
          oct_seen_next = 1'b1;
          phase_next    = PH_OCT;
        end
      end else if (character == CH_HASH) begin
        if (phase == PH_LETTER) begin
          // Only C, D, F, G and A have a sharp; the rest keep their tone.
          if (tone == 4'd0 || tone == 4'd2 || tone == 4'd5 ||
              tone == 4'd7 || tone == 4'd9) begin
            tone_next = tone + 4'd1;
          end
          phase_next = PH_MOD;
        end
      end else if (character == CH_DOT) begin
        if (phase == PH_LETTER) begin
          phase_next = PH_MOD;
        end
      end else if (letter[TONE_W] && phase == PH_PRE) begin
        tone_next  = letter[TONE_W-1:0];
        phase_next = PH_LETTER;
      end
    end
  end

  // The note is judged on the state after this character is taken in.
  assign emit     = close && pending_next;
  assign oct_pick = oct_seen_next ? oct_acc_next : default_octave;
  assign dur_pick = dur_seen_next ? dur_acc_next : default_duration;

  always_comb begin
    if (phase_next == PH_PRE) begin
      note = '{status: STATUS_NO_LETTER, tone: '0, octave: '0, freq: '0, dur: '0};
    end else begin
      note.tone   = tone_next;
      note.octave = oct_pick;
      note.freq   = (tone_next < TONE_REST) ?
                    12'(base_div5(tone_next)) * 12'(oct_pick) : '0;
      note.dur    = dur_pick;
      note.status = (dur_pick == '0) ? STATUS_ZERO_DUR : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && close)) begin
      phase    <= PH_PRE;
      dur_acc  <= '0;
      dur_seen <= 1'b0;
      tone     <= '0;
      oct_acc  <= '0;
      oct_seen <= 1'b0;
      pending  <= 1'b0;
    end else if (accept) begin
      phase    <= phase_next;
      dur_acc  <= dur_acc_next;
      dur_seen <= dur_seen_next;
      tone     <= tone_next;
      oct_acc  <= oct_acc_next;
      oct_seen <= oct_seen_next;
      pending  <= pending_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ringtone_note_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Ringtone note parser. Characters of the melody's note section arrive one per
// transaction on the slave side; a comma, or a character marked with s_tlast,
// closes the note that is being built, and one result transaction follows on
// the master side for every closed note that held anything but spaces. A
// character that closes no note leaves the slave side ready. A note that closes
// with a valid duration runs a shared restoring divider for whole_note_ms /
// duration, one quotient bit per cycle; the sequencer then sees the divider
// finish and loads the result register once it is free, and the next
// character is taken no earlier than the cycle after that. A note without a
// letter or with a zero duration skips the divider and goes straight to the
// load state, which also waits for the output register to be free. The slave
// side is not ready while the divider runs or while a result waits to be
// loaded; a finished result sits in its own output register, so the next
// characters are taken while it waits for m_tready. Configuration writes are
// taken at any time but should only be made while the block is idle.
module ringtone_note_parser (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Configuration write port.
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [rtp_pkg::MS_W-1:0]        cfg_data,
  // Character stream.
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [rtp_pkg::CHAR_W-1:0]      s_tdata,   // [7:0] character
  input  wire logic                           s_tlast,   // last_char
  // Note results.
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // [3:0] tone_index, [7:4] octave_used, [19:8] frequency_hz,
  // [35:20] duration_ms, [39:36] zero
  output logic [rtp_pkg::OUT_DATA_W-1:0]       m_tdata,
  output logic [rtp_pkg::STATUS_W-1:0]         m_tuser    // [1:0] status
);
  import rtp_pkg::*;

  // Configuration registers.
  logic [DUR_W-1:0] default_duration;
  logic [OCT_W-1:0] default_octave;
  logic [MS_W-1:0]  whole_note_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_duration <= 8'd4;
      default_octave   <= 4'd6;
      whole_note_ms    <= 16'd952;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEFAULT_DURATION: default_duration <= cfg_data[DUR_W-1:0];
        CFG_DEFAULT_OCTAVE:   default_octave   <= cfg_data[OCT_W-1:0];
        CFG_WHOLE_NOTE_MS:    whole_note_ms    <= cfg_data;
        default:              ;
      endcase
    end
  end

  // The parser sees every accepted character.
  logic  in_accept;
  logic  emit;
  note_t note_now;
  note_t note_held;

  assign in_accept = s_tvalid && s_tready;

  rtp_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .accept           (in_accept),
    .character        (s_tdata),
    .last_char        (s_tlast),
    .default_duration (default_duration),
    .default_octave   (default_octave),
    .emit             (emit),
    .note             (note_now)
  );

  // Shared divider for the note length.
  logic            div_start;
  logic            div_done;
  logic [MS_W-1:0] quotient;

  rtp_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (whole_note_ms),
    .divisor  (note_now.dur),
    .done     (div_done),
    .quotient (quotient)
  );

  // Sequencer: take characters, run the divider for a closing OK note, then
  // load the result once the output register is free.
  seq_state_t state, state_next;
  logic       load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && emit) begin
          if (note_now.status == STATUS_OK) begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end else begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        load_out = !m_tvalid || m_tready;
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The closed note is kept while the divider works.
  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      note_held <= note_now;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {4'd0,
                  (note_held.status == STATUS_OK) ? quotient : 16'd0,
                  note_held.freq,
                  note_held.octave,
                  note_held.tone};
      m_tuser <= note_held.status;
    end
  end

`ifndef SYNTH
  // The divider only finishes a division that the sequencer waits for.
  assert property (@(posedge clk) disable iff (rst) div_done |-> state == ST_DIV)
    else $error("divider finished outside of a division");

  // A result is never written over one that has not been taken.
  assert property (@(posedge clk) disable iff (rst) load_out |-> (!m_tvalid || m_tready))
    else $error("result register overwritten");

  // A note without a letter carries all-zero fields.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == STATUS_NO_LETTER) |-> m_tdata == '0)
    else $error("note without letter carries data");
`endif

endmodule

`default_nettype wire

@@ dv/ringtone_note_parser_tb.sv @@
`timescale 1ns / 1ps

module ringtone_note_parser_tb;
  import rtp_pkg::*;

  // Far above the slowest correct run: about 1400 characters, each with at most
  // one division plus sender gaps and receiver stalls.
  localparam int CYCLE_LIMIT = 500000;
  // Quiet cycles after the divider path from a closing character to its result,
  // so that the block is idle before a register write.
  localparam int SETTLE_CYCLES = 25;
  // Non-space characters sent per random segment.
  localparam int SEGMENT_CHARS = 220;

  // Tracks the note parser: it follows every accepted character with its own
  // copy of the parse state and registers, keeps the notes that must come out
  // in order, and compares each result transaction against the oldest one.
  class note_checker;
    typedef struct packed {
      logic [TONE_W-1:0]   tone;
      logic [OCT_W-1:0]    octave;
      logic [FREQ_W-1:0]   freq;
      logic [MS_W-1:0]     ms;
      logic [STATUS_W-1:0] status;
    } note_fields_t;

    note_fields_t expected_notes[$];

    // Register copies.
    logic [DUR_W-1:0] dflt_dur;
    logic [OCT_W-1:0] dflt_oct;
    logic [MS_W-1:0]  whole_ms;

    // State of the note being assembled.
    phase_t            phase;
    logic [DUR_W-1:0]  dur_acc;
    bit                dur_seen;
    logic [TONE_W-1:0] tone;
    logic [OCT_W-1:0]  oct_acc;
    bit                oct_seen;
    bit                pending;

    int errors;
    int checked;
    int rests;
    int no_letter;
    int zero_dur;

    function new();
      dflt_dur = 8'd4;
      dflt_oct = 4'd6;
      whole_ms = 16'd952;
      clear_note();
    endfunction

    function void set_regs(logic [DUR_W-1:0] dur, logic [OCT_W-1:0] oct, logic [MS_W-1:0] ms);
      dflt_dur = dur;
      dflt_oct = oct;
      whole_ms = ms;
    endfunction

    function void clear_note();
      phase    = PH_PRE;
      dur_acc  = '0;
      dur_seen = 0;
      tone     = '0;
      oct_acc  = '0;
      oct_seen = 0;
      pending  = 0;
    endfunction

    // Frequency of the semitone in the base octave, in Hz.
    function int unsigned pitch_hz(logic [TONE_W-1:0] st);
      case (st)
        4'd0:    return 523;
        4'd1:    return 554;
        4'd2:    return 587;
        4'd3:    return 622;
        4'd4:    return 660;
        4'd5:    return 698;
        4'd6:    return 740;
        4'd7:    return 784;
        4'd8:    return 831;
        4'd9:    return 880;
        4'd10:   return 932;
        4'd11:   return 988;
        default: return 0;
      endcase
    endfunction

    // Maps a note letter to its semitone; returns 0 for anything else.
    function bit letter_semitone(logic [CHAR_W-1:0] c, output logic [TONE_W-1:0] st);
      st = '0;
      case (c)
        "c":     st = 4'd0;
        "d":     st = 4'd2;
        "e":     st = 4'd4;
        "f":     st = 4'd5;
        "g":     st = 4'd7;
        "a":     st = 4'd9;
        "b":     st = 4'd11;
        "p":     st = TONE_REST;
        default: return 0;
      endcase
      return 1;
    endfunction

    function void close_note();
      note_fields_t n;
      int unsigned dur;
      n = '0;
      if (phase == PH_PRE) begin
        n.status = STATUS_NO_LETTER;
        no_letter++;
      end else begin
        n.tone   = tone;
        n.octave = oct_seen ? oct_acc : dflt_oct;
        dur      = dur_seen ? dur_acc : dflt_dur;
        if (tone != TONE_REST)
          n.freq = FREQ_W'((pitch_hz(tone) / 5) * n.octave);
        else
          rests++;
        if (dur == 0) begin
          n.status = STATUS_ZERO_DUR;
          zero_dur++;
        end else begin
          n.ms     = MS_W'(whole_ms / dur);
          n.status = STATUS_OK;
        end
      end
      expected_notes.push_back(n);
    endfunction

    // Follows one accepted character transaction.
    function void take_char(logic [CHAR_W-1:0] c, logic last);
      int unsigned v;
      logic [TONE_W-1:0] st;
      if (c == CH_COMMA) begin
        if (pending) close_note();
        clear_note();
        return;
      end
      if (c != CH_SPACE) begin
        pending = 1;
        if (c >= CH_ZERO && c <= CH_NINE) begin
          if (phase == PH_PRE) begin
            v = dur_acc * 10 + (c - CH_ZERO);
            dur_acc  = (v > 255) ? 8'd255 : DUR_W'(v);
            dur_seen = 1;
          end else begin
            v = oct_acc * 10 + (c - CH_ZERO);
            oct_acc  = (v > 15) ? 4'd15 : OCT_W'(v);
            oct_seen = 1;
            phase    = PH_OCT;
          end
        end else if (c == CH_HASH) begin
          if (phase == PH_LETTER) begin
            // Only C, D, F, G and A have a sharp; E, B and a rest keep their tone.
            case (tone)
              4'd0, 4'd2, 4'd5, 4'd7, 4'd9: tone = tone + 1'b1;
              default: ;
            endcase
            phase = PH_MOD;
          end
        end else if (c == CH_DOT) begin
          if (phase == PH_LETTER) phase = PH_MOD;
        end else if (letter_semitone(c, st) && phase == PH_PRE) begin
          tone  = st;
          phase = PH_LETTER;
        end
      end
      if (last) begin
        if (pending) close_note();
        clear_note();
      end
    endfunction

    function void flag(string field, int unsigned exp_val, int unsigned act_val);
      errors++;
      if (errors <= 10)
        $display("Note %0d, %s: expected %0d, actual %0d", checked, field, exp_val, act_val);
    endfunction

    // Compares one accepted result transaction with the oldest expected note.
    function void match_note(logic [OUT_DATA_W-1:0] d, logic [STATUS_W-1:0] st);
      note_fields_t e;
      checked++;
      if (expected_notes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Note %0d arrived with none expected: tdata %h, status %0d", checked, d, st);
        return;
      end
      e = expected_notes.pop_front();
      if (d[3:0] !== e.tone)    flag("tone_index", e.tone, d[3:0]);
      if (d[7:4] !== e.octave)  flag("octave_used", e.octave, d[7:4]);
      if (d[19:8] !== e.freq)   flag("frequency_hz", e.freq, d[19:8]);
      if (d[35:20] !== e.ms)    flag("duration_ms", e.ms, d[35:20]);
      if (d[39:36] !== 4'd0)    flag("tdata padding", 0, d[39:36]);
      if (st !== e.status)      flag("status", e.status, st);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_we    = 1'b0;
  logic [1:0]            cfg_index = CFG_DEFAULT_DURATION;
  logic [MS_W-1:0]       cfg_data  = '0;

  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [CHAR_W-1:0]     s_tdata   = '0;
  logic                  s_tlast   = 1'b0;

  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]   m_tuser;

  note_checker tracker = new();

  // Percent of cycles in which each side holds off.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int chars_sent = 0;
  int settings_used = 0;
  int cycle_count = 0;

  ringtone_note_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // A hung handshake must not run forever.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d notes still expected.",
               cycle_count, tracker.expected_notes.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result side. Values are sampled as they stood just before the edge, so a
  // transaction is counted exactly when tvalid and tready were both high.
  // The ready line is then redrawn for the next cycle at the current rate.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      tracker.match_note(m_tdata, m_tuser);
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offers one character and holds it until the block takes it. Afterwards
  // the sender may go quiet for a random number of cycles; when it does not,
  // tvalid simply stays high for the next character, so it is never lowered
  // and raised within one time step.
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.take_char(c, last);
    if (c != CH_SPACE) chars_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      // Junk on the data lines while idle must be ignored.
      s_tvalid <= 1'b0;
      s_tdata  <= CHAR_W'($urandom);
      s_tlast  <= 1'($urandom);
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Stops sending and waits until every expected note has been checked, then
  // lets the divider settle in case a note is still in flight.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (tracker.expected_notes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges; the block is idle here.
  task automatic load_settings(input logic [DUR_W-1:0] dur, input logic [OCT_W-1:0] oct,
                               input logic [MS_W-1:0] ms);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEFAULT_DURATION;
    cfg_data  <= MS_W'(dur);
    @(posedge clk);
    cfg_index <= CFG_DEFAULT_OCTAVE;
    cfg_data  <= MS_W'(oct);
    @(posedge clk);
    cfg_index <= CFG_WHOLE_NOTE_MS;
    cfg_data  <= ms;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.set_regs(dur, oct, ms);
    settings_used++;
  endtask

  // Builds one note. Most are well formed (duration digits, letter, sharp,
  // dot, octave digits, each optional but the letter) so that every parse
  // phase is reached; the rest are scrambled notes and raw bytes.
  task automatic send_random_note();
    logic [CHAR_W-1:0] seq[$];
    string letters = "abcdefgp";
    string junk = "0123456789abcdefgp#.#. ,AGZ!~";
    int kind;
    int close_kind;
    bit by_last;
    kind = $urandom_range(99);
    if ($urandom_range(9) == 0) seq.push_back(CH_SPACE);
    if (kind < 75) begin
      repeat ($urandom_range(3)) seq.push_back(CH_ZERO + CHAR_W'($urandom_range(9)));
      seq.push_back(letters[$urandom_range(7)]);
      if ($urandom_range(2) == 0) seq.push_back(CH_HASH);
      if ($urandom_range(3) == 0) seq.push_back(CH_DOT);
      repeat ($urandom_range(2)) seq.push_back(CH_ZERO + CHAR_W'($urandom_range(9)));
    end else if (kind < 90) begin
      repeat ($urandom_range(6, 1)) seq.push_back(junk[$urandom_range(junk.len() - 1)]);
    end else begin
      repeat ($urandom_range(4, 1)) seq.push_back(CHAR_W'($urandom_range(255)));
    end
    // Mostly closed by a comma, sometimes by the last-character flag alone,
    // and sometimes by a comma that carries the flag as well.
    close_kind = $urandom_range(9);
    by_last = (close_kind == 0);
    foreach (seq[i])
      send_char(seq[i], by_last && i == seq.size() - 1);
    if (!by_last) send_char(CH_COMMA, close_kind == 1);
  endtask

  task automatic run_random_notes(input int quota);
    int start;
    start = chars_sent;
    while (chars_sent - start < quota) begin
      send_random_note();
      if ($urandom_range(49) == 0) wait_for_results();
    end
    // A flagged comma leaves the parser empty before the next register write.
    send_char(CH_COMMA, 1'b1);
    wait_for_results();
  endtask

  initial begin
    // Directed notes under the reset values: a bare rest, saturated duration
    // and octave digits with a sharp that has no effect and a dot, a zero
    // duration with octave zero, a note with no letter, empty notes, and a
    // note with a second letter and stray marks that the last flag closes.
    string directed = "p,999b#.99,0c#0,X, ,,d#e.#4";

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 54;
    for (int i = 0; i < directed.len(); i++)
      send_char(directed[i], i == directed.len() - 1);
    wait_for_results();

    // Largest default duration and octave, then duration 1, octave 0 and a 1 ms whole note.
    load_settings(8'd255, 4'd15, 16'd60000);
    run_random_notes(SEGMENT_CHARS);
    load_settings(8'd1, 4'd0, 16'd1);
    run_random_notes(SEGMENT_CHARS);

    send_idle_pct = 54;
    recv_idle_pct = 30;
    load_settings(DUR_W'($urandom_range(255, 1)), OCT_W'($urandom_range(15)),
                  MS_W'($urandom_range(60000, 1)));
    run_random_notes(SEGMENT_CHARS);
    load_settings(8'd32, 4'd5, 16'd1875);
    run_random_notes(SEGMENT_CHARS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_settings(8'd4, 4'd6, 16'd952);
    run_random_notes(SEGMENT_CHARS);
    load_settings(DUR_W'($urandom_range(255, 1)), OCT_W'($urandom_range(15)),
                  MS_W'($urandom_range(60000, 1)));
    run_random_notes(SEGMENT_CHARS);

    wait_for_results();
    $display("Sent %0d characters under %0d register settings; checked %0d notes.",
             chars_sent, settings_used + 1, tracker.checked);
    $display("Among them %0d rests, %0d without a letter, %0d with zero duration; %0d mismatches.",
             tracker.rests, tracker.no_letter, tracker.zero_dur, tracker.errors);
    if (tracker.errors == 0 && tracker.expected_notes.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ files.f @@
rtl/rtp_pkg.sv
rtl/rtp_divider.sv
rtl/rtp_parser.sv
rtl/ringtone_note_parser.sv
dv/ringtone_note_parser_tb.sv
